### design/sicxe_pkg.sv
// ----------------------------------------------------------------------------
// sicxe_pkg
// Shared types and constants for the SIC/XE instruction executor.
// ----------------------------------------------------------------------------
package sicxe_pkg;

    localparam int MemAddrBitsDefault = 16;
    localparam int RegW = 24;

    typedef enum logic [1:0] {
        K_WRITE   = 2'd0,
        K_READ    = 2'd1,
        K_RESTART = 2'd2,
        K_EXEC    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_EXEC    = 2'd1,
        ST_END     = 2'd2,
        ST_UNKNOWN = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CC_UNSET   = 2'd0,
        CC_LESS    = 2'd1,
        CC_EQUAL   = 2'd2,
        CC_GREATER = 2'd3
    } t_cc;

    // opcodes (upper six bits of the first byte, low bits zero)
    localparam logic [7:0] OP_LDA  = 8'd0;
    localparam logic [7:0] OP_STA  = 8'd12;
    localparam logic [7:0] OP_STX  = 8'd16;
    localparam logic [7:0] OP_STL  = 8'd20;
    localparam logic [7:0] OP_COMP = 8'd40;
    localparam logic [7:0] OP_JEQ  = 8'd48;
    localparam logic [7:0] OP_JGT  = 8'd52;
    localparam logic [7:0] OP_JLT  = 8'd56;
    localparam logic [7:0] OP_J    = 8'd60;
    localparam logic [7:0] OP_JSUB = 8'd72;
    localparam logic [7:0] OP_RSUB = 8'd76;
    localparam logic [7:0] OP_LDCH = 8'd80;
    localparam logic [7:0] OP_STCH = 8'd84;
    localparam logic [7:0] OP_LDB  = 8'd104;
    localparam logic [7:0] OP_LDT  = 8'd116;
    localparam logic [7:0] OP_COMPR = 8'd160;
    localparam logic [7:0] OP_CLEAR = 8'd180;
    localparam logic [7:0] OP_TIXR = 8'd184;
    localparam logic [7:0] OP_RD   = 8'd216;
    localparam logic [7:0] OP_TD   = 8'd224;
    localparam logic [7:0] OP_WD   = 8'd220;

    localparam logic [3:0] R_A = 4'd0;
    localparam logic [3:0] R_X = 4'd1;
    localparam logic [3:0] R_L = 4'd2;
    localparam logic [3:0] R_B = 4'd3;
    localparam logic [3:0] R_S = 4'd4;
    localparam logic [3:0] R_T = 4'd5;
    localparam logic [3:0] R_F = 4'd6;
    localparam logic [3:0] R_PC = 4'd8;
    localparam logic [3:0] R_SW = 4'd9;

    localparam logic [1:0] CFG_START = 2'd0;
    localparam logic [1:0] CFG_END   = 2'd1;
    localparam logic [1:0] CFG_LEN   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_F0,
        S_F1,
        S_F2,
        S_F3,
        S_DEC,
        S_RD0,
        S_RD1,
        S_RD2,
        S_WR0,
        S_WR1,
        S_WR2,
        S_EXE,
        S_ACC,
        S_OUT
    } t_state;

    function automatic t_cc cmp24(input logic [RegW-1:0] a, input logic [RegW-1:0] b);
        if (a > b)
            return CC_GREATER;
        else if (a == b)
            return CC_EQUAL;
        return CC_LESS;
    endfunction

endpackage

### design/sicxe_if.sv
// ----------------------------------------------------------------------------
// sicxe_in_if / sicxe_out_if
// Valid/ready channels for input items and result words.
// ----------------------------------------------------------------------------
interface sicxe_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  data;
    modport source (output valid, kind, address, data, input ready);
    modport sink (input valid, kind, address, data, output ready);
endinterface

interface sicxe_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  read_data;
    logic [15:0] pc;
    logic [23:0] reg_a;
    logic [23:0] reg_x;
    logic [23:0] reg_l;
    logic [23:0] reg_b;
    logic [23:0] reg_s;
    logic [23:0] reg_t;
    logic [1:0]  cond_code;
    modport source (output valid, status, read_data, pc, reg_a, reg_x, reg_l, reg_b,
                    reg_s, reg_t, cond_code, input ready);
    modport sink (input valid, status, read_data, pc, reg_a, reg_x, reg_l, reg_b,
                  reg_s, reg_t, cond_code, output ready);
endinterface

### design/sicxe_instruction_executor_core.sv
// ----------------------------------------------------------------------------
// sicxe_instruction_executor_core
// SIC/XE subset processor with a private byte memory.
// ----------------------------------------------------------------------------
// One word at a time: the next input word is taken only after the result word
// has been taken. A memory write or read runs through S_ACC and S_OUT, a restart
// or program end only through S_OUT. An instruction always fetches 3 bytes, or
// 4 for format 4, through the single byte-wide memory port, one byte per cycle,
// then a decode state follows. A 3-byte operand read runs through S_RD0, S_RD1
// and S_RD2, LDCH through S_RD0 and S_RD1. A 3-byte store writes a byte on each
// pass through S_WR0, STCH a single byte. The execute and output states come
// last. The result word is held in an output register until it is taken.
module sicxe_instruction_executor_core
    import sicxe_pkg::*;
#(
    parameter int MEM_ADDR_BITS = MemAddrBitsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sicxe_in_if.sink    in_ch,
    sicxe_out_if.source out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW = MEM_ADDR_BITS;

    logic [15:0] r_start, r_len;
    logic [16:0] r_end;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0; r_end <= '0; r_len <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                CFG_START: r_start <= pwdata[15:0];
                CFG_END:   r_end <= pwdata[16:0];
                CFG_LEN:   r_len <= pwdata[15:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        case (paddr[3:2])
            CFG_START: prdata = {16'd0, r_start};
            CFG_END:   prdata = {15'd0, r_end};
            CFG_LEN:   prdata = {16'd0, r_len};
            default:   prdata = '0;
        endcase
    end

    t_state r_st, n_st;
    logic [RegW-1:0] r_rf [10];
    logic [AW-1:0]   r_pc;
    t_cc             r_cc;
    logic [1:0]      r_kind;
    logic [AW-1:0]   r_addr;
    logic [7:0]      r_data;
    logic [7:0]      r_b0, r_b1, r_b2, r_b3;
    logic [RegW-1:0] r_ta, r_val;
    logic [1:0]      r_status;
    logic [7:0]      r_rdata;
    logic            r_ovalid;

    logic            mem_we;
    logic [AW-1:0]   mem_addr;
    logic [7:0]      mem_wdata, mem_rdata;

    sicxe_mem #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_mem (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(mem_addr),
        .i_wdata(mem_wdata), .o_rdata(mem_rdata)
    );

    logic [7:0] op;
    logic       bn, bi, fmt2, ext;
    assign op   = {r_b0[7:2], 2'b00};
    assign bn   = r_b0[1];
    assign bi   = r_b0[0];
    assign fmt2 = (op == OP_COMPR) || (op == OP_CLEAR) || (op == OP_TIXR);
    assign ext  = (bn || bi) && r_b1[4];

    logic is_store, needs3, is_ldch, is_stch;
    assign is_store = (op == OP_STA) || (op == OP_STX) || (op == OP_STL);
    assign is_ldch  = op == OP_LDCH;
    assign is_stch  = op == OP_STCH;
    assign needs3   = (bn && bi && ((op == OP_LDA) || (op == OP_LDB) || (op == OP_LDT) ||
                       (op == OP_COMP))) || (bn && !bi && op == OP_J);

    logic at_end;
    assign at_end = 32'(r_pc) >= 32'(r_end);

    logic [RegW-1:0] store_val;
    always_comb begin
        case (op)
            OP_STL:  store_val = r_rf[R_L];
            OP_STX:  store_val = r_rf[R_X];
            default: store_val = r_rf[R_A];
        endcase
    end

    // target address, computed in S_DEC from fetched bytes
    logic [AW-1:0]   pc_len;
    logic [RegW-1:0] ta_c, disp_c;
    always_comb begin
        disp_c = {12'd0, r_b1[3:0], r_b2};
        if (fmt2)
            pc_len = AW'(2);
        else if (ext)
            pc_len = AW'(4);
        else
            pc_len = AW'(3);
        if (!bn && !bi)
            ta_c = {9'd0, r_b1[6:0], r_b2};
        else if (ext)
            ta_c = {4'd0, r_b1[3:0], r_b2, r_b3};
        else if (r_b1[6])
            ta_c = disp_c + r_rf[R_B];
        else if (r_b1[5])
            ta_c = {{12{r_b1[3]}}, r_b1[3:0], r_b2} + RegW'(AW'(r_pc + pc_len));
        else
            ta_c = disp_c;
        if (r_b1[7])
            ta_c = ta_c + r_rf[R_X];
    end

    logic [1:0] acc_cnt;
    logic [1:0] r_cnt;
    logic [3:0] r1, r2;
    logic [RegW-1:0] g1, g2, x_inc;
    assign r1 = r_b1[7:4];
    assign r2 = r_b1[3:0];
    assign g1 = (r1 < 4'd10) ? r_rf[r1] : '0;
    assign g2 = (r2 < 4'd10) ? r_rf[r2] : '0;
    assign x_inc = r_rf[R_X] + RegW'(1);
    assign acc_cnt = r_cnt;

    logic in_fire, out_fire;
    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign in_ch.ready = (r_st == S_IDLE) && !r_ovalid;

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (in_fire) begin
                case (t_kind'(in_ch.kind))
                    K_WRITE, K_READ: n_st = S_ACC;
                    K_RESTART:       n_st = S_OUT;
                    default:         n_st = at_end ? S_OUT : S_F0;
                endcase
            end
            S_ACC: n_st = S_OUT;
            S_F0:  n_st = S_F1;
            S_F1:  n_st = S_F2;
            S_F2:  n_st = (fmt2 || (!bn && !bi) || !r_b1[4]) ? S_DEC : S_F3;
            S_F3:  n_st = S_DEC;
            S_DEC: begin
                if (needs3 || is_ldch)
                    n_st = S_RD0;
                else if (is_store || is_stch)
                    n_st = S_WR0;
                else
                    n_st = S_EXE;
            end
            S_RD0: n_st = S_RD1;
            // LDCH has its byte in r_val after the first S_RD1
            S_RD1: n_st = is_ldch ? S_EXE : ((acc_cnt == 2'd2) ? S_RD2 : S_RD1);
            S_RD2: n_st = S_EXE;
            S_WR0: n_st = (is_stch || acc_cnt == 2'd2) ? S_EXE : S_WR0;
            S_EXE: n_st = S_OUT;
            S_OUT: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_pc;
        mem_wdata = r_data;
        case (r_st)
            S_IDLE: mem_addr = r_pc;
            S_ACC: begin
                mem_addr = r_addr;
                mem_we   = (r_kind == K_WRITE);
            end
            S_F0: mem_addr = AW'(r_pc + AW'(1));
            S_F1: mem_addr = AW'(r_pc + AW'(2));
            S_F2: mem_addr = AW'(r_pc + AW'(3));
            S_RD0, S_RD1: mem_addr = AW'(r_ta[AW-1:0] + AW'(r_cnt));
            S_WR0: begin
                mem_we   = 1'b1;
                mem_addr = AW'(r_ta[AW-1:0] + AW'(r_cnt));
                if (is_stch)
                    mem_wdata = r_rf[R_A][7:0];
                else begin
                    case (r_cnt)
                        2'd0:    mem_wdata = store_val[23:16];
                        2'd1:    mem_wdata = store_val[15:8];
                        default: mem_wdata = store_val[7:0];
                    endcase
                end
            end
            default: ;
        endcase
    end

    logic [RegW-1:0] val_in;
    always_comb begin
        val_in = '0;
        if (bn && bi)
            val_in = r_val;
        else if (!bn && bi)
            val_in = r_ta;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_pc     <= '0;
            r_cc     <= CC_UNSET;
            r_ovalid <= 1'b0;
            for (int k = 0; k < 10; k++)
                r_rf[k] <= '0;
        end else begin
            r_st <= n_st;
            if (out_fire)
                r_ovalid <= 1'b0;
            case (r_st)
                S_IDLE: if (in_fire) begin
                    r_kind   <= in_ch.kind;
                    r_addr   <= AW'(in_ch.address);
                    r_data   <= in_ch.data;
                    r_rdata  <= '0;
                    r_status <= (t_kind'(in_ch.kind) == K_EXEC && at_end) ? ST_END : ST_DONE;
                    r_cnt    <= '0;
                    if (t_kind'(in_ch.kind) == K_RESTART) begin
                        for (int k = 0; k < 10; k++) begin
                            if (k == int'(R_L))
                                r_rf[k] <= {8'd0, r_len};
                            else if (k == int'(R_PC))
                                r_rf[k] <= {8'd0, r_start};
                            else
                                r_rf[k] <= '0;
                        end
                        r_pc <= AW'(r_start);
                    end else if (t_kind'(in_ch.kind) == K_EXEC && at_end) begin
                        r_pc <= AW'(r_start);
                    end
                end
                S_ACC: ;
                S_F0: r_b0 <= mem_rdata;
                S_F1: r_b1 <= mem_rdata;
                S_F2: r_b2 <= mem_rdata;
                S_F3: r_b3 <= mem_rdata;
                S_DEC: begin
                    r_ta  <= ta_c;
                    r_pc  <= AW'(r_pc + pc_len);
                    r_cnt <= '0;
                    r_val <= '0;
                end
                S_RD0: r_cnt <= r_cnt + 2'd1;
                S_RD1, S_RD2: begin
                    r_val <= {r_val[15:0], mem_rdata};
                    if (r_st == S_RD1)
                        r_cnt <= r_cnt + 2'd1;
                end
                S_WR0: r_cnt <= r_cnt + 2'd1;
                S_EXE: begin
                    r_status <= (op inside {OP_LDA, OP_STA, OP_STX, OP_STL, OP_COMP, OP_JEQ,
                                            OP_JGT, OP_JLT, OP_J, OP_JSUB, OP_RSUB, OP_LDCH,
                                            OP_STCH, OP_LDB, OP_LDT, OP_COMPR, OP_CLEAR,
                                            OP_TIXR, OP_RD, OP_TD, OP_WD}) ?
                                ST_EXEC : ST_UNKNOWN;
                    case (op)
                        OP_STA, OP_STX, OP_STL, OP_STCH, OP_WD: ;
                        OP_LDA: if (bi) r_rf[R_A] <= val_in;
                        OP_LDB: if (bi) r_rf[R_B] <= val_in;
                        OP_LDT: if (bi) r_rf[R_T] <= val_in;
                        OP_RD:  r_rf[R_A][7:0] <= 8'd0;
                        OP_TD:  r_cc <= CC_LESS;
                        OP_LDCH: r_rf[R_A][7:0] <= r_val[7:0];
                        OP_RSUB: r_pc <= r_rf[R_L][AW-1:0];
                        OP_COMP: r_cc <= cmp24(r_rf[R_A], val_in);
                        OP_CLEAR: if (r1 < 4'd10) r_rf[r1] <= '0;
                        OP_COMPR: r_cc <= cmp24(g1, g2);
                        OP_TIXR: begin
                            r_rf[R_X] <= x_inc;
                            r_cc <= cmp24(x_inc, (r1 == R_X) ? x_inc : g1);
                        end
                        OP_J: begin
                            if (bn && bi)
                                r_pc <= r_ta[AW-1:0];
                            else if (bn)
                                r_pc <= r_val[AW-1:0];
                        end
                        OP_JEQ: if (r_cc == CC_EQUAL) r_pc <= r_ta[AW-1:0];
                        OP_JGT: if (r_cc == CC_GREATER) r_pc <= r_ta[AW-1:0];
                        OP_JLT: if (r_cc == CC_LESS) r_pc <= r_ta[AW-1:0];
                        OP_JSUB: begin
                            r_rf[R_L] <= RegW'(r_pc);
                            r_pc <= r_ta[AW-1:0];
                        end
                        default: ;
                    endcase
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    if (r_kind == K_READ)
                        r_rdata <= mem_rdata;
                end
                default: ;
            endcase
        end
    end

    assign out_ch.valid     = r_ovalid;
    assign out_ch.status    = r_status;
    assign out_ch.read_data = r_rdata;
    assign out_ch.pc        = 16'(r_pc);
    assign out_ch.reg_a     = r_rf[R_A];
    assign out_ch.reg_x     = r_rf[R_X];
    assign out_ch.reg_l     = r_rf[R_L];
    assign out_ch.reg_b     = r_rf[R_B];
    assign out_ch.reg_s     = r_rf[R_S];
    assign out_ch.reg_t     = r_rf[R_T];
    assign out_ch.cond_code = r_cc;
endmodule

### design/sicxe_mem.sv
// ----------------------------------------------------------------------------
// sicxe_mem
// Single-port byte memory, registered read data.
// ----------------------------------------------------------------------------
module sicxe_mem
    import sicxe_pkg::*;
#(
    parameter int MEM_ADDR_BITS = MemAddrBitsDefault
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [MEM_ADDR_BITS-1:0] i_addr,
    input  logic [7:0]               i_wdata,
    output logic [7:0]               o_rdata
);
    logic [7:0] r_mem [2**MEM_ADDR_BITS];

    always_ff @(posedge i_clk) begin
        if (i_we)
            r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule
